/* rtl/pece_pkg.sv */
// Shared definitions for the polynomial easing curve evaluator:
// parameter defaults, curve and direction codes, and a rounding shift.
// No dependencies.
`default_nettype none

package pece_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 16;

	localparam logic [14:0] BACK_DEFAULT = 15'd13939;

	// curve_kind codes
	localparam logic [2:0] CURVE_LINEAR  = 3'd0;
	localparam logic [2:0] CURVE_QUAD    = 3'd1;
	localparam logic [2:0] CURVE_CUBIC   = 3'd2;
	localparam logic [2:0] CURVE_QUART   = 3'd3;
	localparam logic [2:0] CURVE_QUINT   = 3'd4;
	localparam logic [2:0] CURVE_BACK    = 3'd5;
	localparam logic [2:0] CURVE_BOUNCE  = 3'd6;

	// opcode (direction) codes
	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_IN    = 2'd1;
	localparam logic [1:0] DIR_OUT   = 2'd2;
	localparam logic [1:0] DIR_INOUT = 2'd3;

	typedef enum logic [1:0] {
		FAM_LIN    = 2'd0,
		FAM_POW    = 2'd1,
		FAM_BACK   = 2'd2,
		FAM_BOUNCE = 2'd3
	} fam_t;

	// shaping mode: plain in, plain out, first or second half of in-out
	typedef enum logic [1:0] {
		PM_IN  = 2'd0,
		PM_OUT = 2'd1,
		PM_IO1 = 2'd2,
		PM_IO2 = 2'd3
	} pm_t;

	// shift right by sh with rounding to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned sh);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		r = (mag + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

endpackage

`default_nettype wire

/* rtl/pece_div.sv */
// Pipelined restoring divider: rounded elapsed/duration as a fraction,
// one quotient bit per stage, elapsed clamped to duration. Uses pece_pkg.
`default_nettype none

module pece_div import pece_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF,
	parameter int SIDE_W        = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [15:0]              in_elapsed,
	input  logic [15:0]              in_duration,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic [FRACTION_BITS:0]   out_quot,
	output logic [SIDE_W-1:0]        out_side
);

	localparam int F  = FRACTION_BITS;
	localparam int ST = F + 1;
	localparam int NW = 16 + F;

	logic              vld   [0:ST];
	logic [15:0]       rem_s [0:ST];
	logic [F:0]        low_s [0:ST];
	logic [15:0]       den_s [0:ST];
	logic [F:0]        quo_s [0:ST];
	logic [SIDE_W-1:0] side_s[0:ST];

	logic [15:0]   t_clamp;
	logic [NW-1:0] num;

	always_comb begin
		t_clamp = (in_elapsed > in_duration) ? in_duration : in_elapsed;
		num = (NW'(t_clamp) << F) + NW'(in_duration >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= 16'(num[NW-1:F+1]);
			low_s[0]  <= num[F:0];
			den_s[0]  <= in_duration;
			quo_s[0]  <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < ST; k++) begin : g_step
		logic [16:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[k], low_s[k][F]};
			ge = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? 16'(trial - {1'b0, den_s[k]}) : trial[15:0];
				low_s[k+1]  <= low_s[k] << 1;
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= {quo_s[k][F-1:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld[ST];
	assign out_quot  = quo_s[ST];
	assign out_side  = side_s[ST];

endmodule

`default_nettype wire

/* rtl/polynomial_easing_curve_evaluator.sv */
// Top level of the polynomial easing curve evaluator: divider, curve
// shaping stages, scaling, saturation and output skid. Uses pece_pkg, pece_div.
//
//  channel | signals                              | payload (low bit up)
//  --------+--------------------------------------+---------------------------------
//  s       | s_tvalid s_tready s_tdata s_tuser    | elapsed, duration, start, change
//  m       | m_tvalid m_tready m_tdata m_tuser    | eased_value ; saturated
//  cfg     | cfg_valid cfg_ready cfg_data         | back_overshoot
//
// One beat per cycle while the output skid is empty; the divider takes one
// quotient bit per stage and is followed by nine further stages.
// Reset clears all valid bits and loads back_overshoot with 13939.
// After a configuration write the back coefficients settle through bo_q, s_q, x_q and s2_q in that order.
// The pipeline freezes only while the output skid register holds a beat.
`default_nettype none

module polynomial_easing_curve_evaluator import pece_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF,
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// elapsed_time[15:0], total_duration[31:16], start_value[47:32],
	// value_change[64:48], zero[71:65]
	input  logic [71:0] s_tdata,
	// curve_kind[2:0], opcode[4:3]
	input  logic [4:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// eased_value[VALUE_WIDTH-1:0], zero above
	output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
	// saturated[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	localparam int F      = FRACTION_BITS;
	localparam int UW     = F + 1;
	localparam int EW     = F + 7;
	localparam int SW     = F + 3;
	localparam int NX     = F + 6;
	localparam int XW     = F + 5;
	localparam int WW     = F + 6;
	localparam int SIDE_W = 39;
	localparam int OUT_TW = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int RW     = (VALUE_WIDTH > 23) ? VALUE_WIDTH + 1 : 24;

	localparam logic [UW-1:0]        ONE_U  = UW'(64'd1 << F);
	localparam logic [UW-1:0]        HALF_U = UW'(64'd1 << (F - 1));
	localparam logic [2*UW-1:0]      RND_Q  = (2*UW)'(64'd1 << (F - 1));
	localparam logic signed [EW-1:0] ONE_E  = EW'(64'd1 << F);
	localparam logic [XW-1:0]        C4     = XW'(64'd4 << F);
	localparam logic [XW-1:0]        C8     = XW'(64'd8 << F);
	localparam logic [XW-1:0]        C10    = XW'(64'd10 << F);
	localparam logic [UW-1:0]        K2     = UW'((64'd3 << F) / 64'd4);
	localparam logic [UW-1:0]        K3     = UW'((64'd15 << F) / 64'd16);
	localparam logic [UW-1:0]        K4     = UW'((64'd63 << F) / 64'd64);
	localparam logic [NX:0]          RECIP  =
		(NX+1)'(((64'd1 << (NX + 3)) + 64'd4) / 64'd5);
	localparam logic [63:0]          S_RST  = ((64'd13939 << F) + 64'd4096) >> 13;
	localparam logic [63:0]          X_RST  = (S_RST * 64'd61 + 64'd20) >> 3;
	localparam logic [63:0]          S2_RST = (S_RST * 64'd61 + 64'd20) / 64'd40;
	localparam logic signed [RW-1:0] HI     = RW'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
	localparam logic signed [RW-1:0] LO     = -HI - RW'(1);

	// ---------------- configuration and back coefficients ----------------
	logic [14:0]    bo_q;
	logic [SW-1:0]  s_q;
	logic [NX-1:0]  x_q;
	logic [SW-1:0]  s2_q;
	logic [14:0]    sr;
	logic [F+15:0]  s_wide;
	logic [F+8:0]   x_wide;
	logic [2*NX:0]  s2_wide;

	assign cfg_ready = 1'b1;

	always_comb begin
		sr = (bo_q == '0) ? BACK_DEFAULT : bo_q;
		s_wide = ((F+16)'(sr) << F) + (F+16)'(4096);
		x_wide = (F+9)'(s_q) * (F+9)'(61) + (F+9)'(20);
		s2_wide = (2*NX+1)'(x_q) * (2*NX+1)'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bo_q <= BACK_DEFAULT;
			s_q  <= SW'(S_RST);
			x_q  <= NX'(X_RST);
			s2_q <= SW'(S2_RST);
		end else begin
			if (cfg_valid) begin
				bo_q <= cfg_data;
			end
			s_q  <= s_wide[13 +: SW];
			x_q  <= x_wide[F+8:3];
			s2_q <= s2_wide[NX+3 +: SW];
		end
	end

	// ---------------- stall control and divider ----------------
	logic en;
	logic skid_vld_q;

	assign en = !skid_vld_q;
	assign s_tready = en;

	logic [SIDE_W-1:0] in_side;
	logic              div_vld;
	logic [F:0]        div_quot;
	logic [SIDE_W-1:0] div_side;

	assign in_side = {s_tdata[31:16] == 16'd0, s_tuser[4:3], s_tuser[2:0],
		s_tdata[64:48], s_tdata[47:32]};

	pece_div #(
		.FRACTION_BITS (FRACTION_BITS),
		.SIDE_W        (SIDE_W)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.in_elapsed  (s_tdata[15:0]),
		.in_duration (s_tdata[31:16]),
		.in_side     (in_side),
		.out_valid   (div_vld),
		.out_quot    (div_quot),
		.out_side    (div_side)
	);

	// ---------------- stage 1: decode and operands ----------------
	logic               dz1;
	logic [1:0]         op1;
	logic [2:0]         kind1;
	logic [UW-1:0]      ue1;
	logic               first1;
	fam_t               fam1;
	pm_t                pm1;
	logic signed [EW-1:0] ues, px_w, bx_w, by_w;

	always_comb begin
		dz1    = div_side[38];
		op1    = div_side[37:36];
		kind1  = div_side[35:33];
		ue1    = dz1 ? ONE_U : div_quot;
		first1 = ue1 < HALF_U;
		if (dz1 || op1 == DIR_NONE) begin
			fam1 = FAM_LIN;
		end else begin
			case (kind1)
				CURVE_QUAD, CURVE_CUBIC, CURVE_QUART, CURVE_QUINT: fam1 = FAM_POW;
				CURVE_BACK:   fam1 = FAM_BACK;
				CURVE_BOUNCE: fam1 = FAM_BOUNCE;
				default:      fam1 = FAM_LIN;
			endcase
		end
		case (op1)
			DIR_OUT:   pm1 = PM_OUT;
			DIR_INOUT: pm1 = first1 ? PM_IO1 : PM_IO2;
			default:   pm1 = PM_IN;
		endcase
		ues = $signed(EW'(ue1));
		case (pm1)
			PM_OUT: begin
				px_w = ONE_E - ues;
				bx_w = ues - ONE_E;
				by_w = ues;
			end
			PM_IO1: begin
				px_w = ues <<< 1;
				bx_w = ues <<< 1;
				by_w = ONE_E - (ues <<< 1);
			end
			PM_IO2: begin
				px_w = (ONE_E - ues) <<< 1;
				bx_w = (ues - ONE_E) <<< 1;
				by_w = (ues <<< 1) - ONE_E;
			end
			default: begin
				px_w = ues;
				bx_w = ues;
				by_w = ONE_E - ues;
			end
		endcase
	end

	logic                 vld_s1;
	fam_t                 fam_s1;
	pm_t                  pm_s1;
	logic [2:0]           kind_s1;
	logic [UW-1:0]        ue_s1, px_s1, by_s1;
	logic signed [F+1:0]  bx_s1;
	logic signed [15:0]   st_s1;
	logic signed [16:0]   ch_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			fam_s1  <= fam1;
			pm_s1   <= pm1;
			kind_s1 <= kind1;
			ue_s1   <= ue1;
			px_s1   <= px_w[UW-1:0];
			bx_s1   <= bx_w[F+1:0];
			by_s1   <= by_w[UW-1:0];
			st_s1   <= $signed(div_side[15:0]);
			ch_s1   <= $signed(div_side[32:16]);
		end
	end

	// ---------------- stage 2: first products, bounce segment ----------------
	logic [2*UW-1:0]        pp2;
	logic signed [2*F+3:0]  bsq2;
	logic [SW-1:0]          sv2;
	logic signed [F+4:0]    svp2;
	logic signed [2*F+6:0]  bmul2;
	logic signed [63:0]     a2_r, b2_r;
	logic [XW-1:0]          x11;
	logic signed [WW-1:0]   w2;
	logic [UW-1:0]          k2;
	logic                   sh4_2;

	always_comb begin
		pp2   = (2*UW)'(px_s1) * (2*UW)'(px_s1) + RND_Q;
		bsq2  = bx_s1 * bx_s1;
		sv2   = (pm_s1 == PM_IO1 || pm_s1 == PM_IO2) ? s2_q : s_q;
		svp2  = $signed((F+5)'(sv2) + (F+5)'(ONE_U));
		bmul2 = svp2 * bx_s1;
		a2_r  = rnd_shr(64'(bsq2), F);
		b2_r  = rnd_shr(64'(bmul2), F);
		x11   = XW'(by_s1) * XW'(11);
		sh4_2 = 1'b0;
		if (x11 < C4) begin
			w2 = $signed(WW'(x11));
			k2 = '0;
		end else if (x11 < C8) begin
			w2 = $signed(WW'(x11)) - $signed(WW'(64'd6 << F));
			k2 = K2;
		end else if (x11 < C10) begin
			w2 = $signed(WW'(x11)) - $signed(WW'(64'd9 << F));
			k2 = K3;
		end else begin
			w2 = $signed(WW'(by_s1) * WW'(22)) - $signed(WW'(64'd21 << F));
			k2 = K4;
			sh4_2 = 1'b1;
		end
	end

	logic                 vld_s2;
	fam_t                 fam_s2;
	pm_t                  pm_s2;
	logic [2:0]           kind_s2;
	logic [UW-1:0]        ue_s2, px_s2, p_s2, k_s2;
	logic signed [F+1:0]  a_s2;
	logic signed [F+4:0]  b_s2;
	logic [SW-1:0]        sv_s2;
	logic signed [F+3:0]  w_s2;
	logic                 sh4_s2;
	logic signed [15:0]   st_s2;
	logic signed [16:0]   ch_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			fam_s2  <= fam_s1;
			pm_s2   <= pm_s1;
			kind_s2 <= kind_s1;
			ue_s2   <= ue_s1;
			px_s2   <= px_s1;
			p_s2    <= pp2[F +: UW];
			a_s2    <= a2_r[F+1:0];
			b_s2    <= b2_r[F+4:0];
			sv_s2   <= sv2;
			w_s2    <= w2[F+3:0];
			k_s2    <= k2;
			sh4_s2  <= sh4_2;
			st_s2   <= st_s1;
			ch_s2   <= ch_s1;
		end
	end

	// ---------------- stage 3: second products ----------------
	logic [2*UW-1:0]        pp3;
	logic signed [F+5:0]    lin3;
	logic signed [2*F+7:0]  cm3;
	logic signed [2*F+7:0]  wsq3;
	logic signed [63:0]     c3_r, q4_r, q6_r;

	always_comb begin
		pp3  = (2*UW)'(p_s2) * (2*UW)'(px_s2) + RND_Q;
		lin3 = (pm_s2 == PM_IN || pm_s2 == PM_IO1) ?
			(F+6)'(b_s2) - $signed((F+6)'(sv_s2)) :
			(F+6)'(b_s2) + $signed((F+6)'(sv_s2));
		cm3  = a_s2 * lin3;
		c3_r = rnd_shr(64'(cm3), F);
		wsq3 = w_s2 * w_s2;
		q4_r = rnd_shr(64'(wsq3), F + 4);
		q6_r = rnd_shr(64'(wsq3), F + 6);
	end

	logic                 vld_s3;
	fam_t                 fam_s3;
	pm_t                  pm_s3;
	logic [2:0]           kind_s3;
	logic [UW-1:0]        ue_s3, px_s3, p_s3, k_s3, sq_s3;
	logic signed [F+5:0]  c_s3;
	logic signed [15:0]   st_s3;
	logic signed [16:0]   ch_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			fam_s3  <= fam_s2;
			pm_s3   <= pm_s2;
			kind_s3 <= kind_s2;
			ue_s3   <= ue_s2;
			px_s3   <= px_s2;
			p_s3    <= (kind_s2 >= CURVE_CUBIC) ? pp3[F +: UW] : p_s2;
			c_s3    <= c3_r[F+5:0];
			sq_s3   <= sh4_s2 ? q6_r[F:0] : q4_r[F:0];
			k_s3    <= k_s2;
			st_s3   <= st_s2;
			ch_s3   <= ch_s2;
		end
	end

	// ---------------- stage 4: back and bounce finish, third power product ----------------
	logic [2*UW-1:0]       pp4;
	logic signed [EW-1:0]  bv4, bo4, bk4, bn4, alt4;
	logic signed [63:0]    bh4_r;

	always_comb begin
		pp4 = (2*UW)'(p_s3) * (2*UW)'(px_s3) + RND_Q;
		case (pm_s3)
			PM_OUT:  bv4 = EW'(c_s3) + ONE_E;
			PM_IO2:  bv4 = EW'(c_s3) + (ONE_E <<< 1);
			default: bv4 = EW'(c_s3);
		endcase
		bh4_r = rnd_shr(64'(bv4), 1);
		bk4 = (pm_s3 == PM_IO1 || pm_s3 == PM_IO2) ? bh4_r[EW-1:0] : bv4;
		bo4 = $signed(EW'(sq_s3)) + $signed(EW'(k_s3));
		case (pm_s3)
			PM_OUT:  bn4 = bo4;
			PM_IO1:  bn4 = (ONE_E - bo4 + EW'(1)) >>> 1;
			PM_IO2:  bn4 = (bo4 + ONE_E + EW'(1)) >>> 1;
			default: bn4 = ONE_E - bo4;
		endcase
		alt4 = (fam_s3 == FAM_BACK) ? bk4 : bn4;
	end

	logic                  vld_s4;
	fam_t                  fam_s4;
	pm_t                   pm_s4;
	logic [2:0]            kind_s4;
	logic [UW-1:0]         ue_s4, px_s4, p_s4;
	logic signed [EW-1:0]  alt_s4;
	logic signed [15:0]    st_s4;
	logic signed [16:0]    ch_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			fam_s4  <= fam_s3;
			pm_s4   <= pm_s3;
			kind_s4 <= kind_s3;
			ue_s4   <= ue_s3;
			px_s4   <= px_s3;
			p_s4    <= (kind_s3 >= CURVE_QUART) ? pp4[F +: UW] : p_s3;
			alt_s4  <= alt4;
			st_s4   <= st_s3;
			ch_s4   <= ch_s3;
		end
	end

	// ---------------- stage 5: last power product ----------------
	logic [2*UW-1:0] pp5;

	assign pp5 = (2*UW)'(p_s4) * (2*UW)'(px_s4) + RND_Q;

	logic                  vld_s5;
	fam_t                  fam_s5;
	pm_t                   pm_s5;
	logic [UW-1:0]         ue_s5, p_s5;
	logic signed [EW-1:0]  alt_s5;
	logic signed [15:0]    st_s5;
	logic signed [16:0]    ch_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			fam_s5 <= fam_s4;
			pm_s5  <= pm_s4;
			ue_s5  <= ue_s4;
			p_s5   <= (kind_s4 >= CURVE_QUINT) ? pp5[F +: UW] : p_s4;
			alt_s5 <= alt_s4;
			st_s5  <= st_s4;
			ch_s5  <= ch_s4;
		end
	end

	// ---------------- stage 6: select eased fraction ----------------
	logic signed [EW-1:0] pe6, pw6, e6;

	always_comb begin
		pe6 = $signed(EW'(p_s5));
		case (pm_s5)
			PM_OUT:  pw6 = ONE_E - pe6;
			PM_IO1:  pw6 = (pe6 + EW'(1)) >>> 1;
			PM_IO2:  pw6 = ONE_E - ((pe6 + EW'(1)) >>> 1);
			default: pw6 = pe6;
		endcase
		case (fam_s5)
			FAM_POW:              e6 = pw6;
			FAM_BACK, FAM_BOUNCE: e6 = alt_s5;
			default:              e6 = $signed(EW'(ue_s5));
		endcase
	end

	logic                  vld_s6;
	fam_t                  fam_s6;
	logic signed [EW-1:0]  e_s6;
	logic signed [15:0]    st_s6;
	logic signed [16:0]    ch_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			fam_s6 <= fam_s5;
			e_s6   <= e6;
			st_s6  <= st_s5;
			ch_s6  <= ch_s5;
		end
	end

	// ---------------- stage 7: scale change ----------------
	logic                    vld_s7;
	logic signed [EW+16:0]   prod_s7;
	logic signed [15:0]      st_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= ch_s6 * e_s6;
			st_s7   <= st_s6;
		end
	end

	// ---------------- stage 8: round and add start ----------------
	logic signed [63:0]   rq8_r;
	logic signed [RW-1:0] r8;

	always_comb begin
		rq8_r = rnd_shr(64'(prod_s7), F);
		r8 = RW'(st_s7) + rq8_r[RW-1:0];
	end

	logic                  vld_s8;
	logic signed [RW-1:0]  r_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s8 <= r8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= div_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// ---------------- stage 9: saturate, output register and skid ----------------
	logic [VALUE_WIDTH-1:0] val9;
	logic                   sat9;
	logic                   incoming;
	logic                   out_free;
	logic                   vld_s9;
	logic [VALUE_WIDTH-1:0] val_s9, skid_val_q;
	logic                   sat_s9, skid_sat_q;

	always_comb begin
		if (r_s8 > HI) begin
			val9 = HI[VALUE_WIDTH-1:0];
			sat9 = 1'b1;
		end else if (r_s8 < LO) begin
			val9 = LO[VALUE_WIDTH-1:0];
			sat9 = 1'b1;
		end else begin
			val9 = r_s8[VALUE_WIDTH-1:0];
			sat9 = 1'b0;
		end
		incoming = en && vld_s8;
		out_free = !vld_s9 || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9     <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			// drain the skid first; no beat arrives while it is full
			vld_s9     <= skid_vld_q || incoming;
			skid_vld_q <= 1'b0;
		end else if (incoming) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			val_s9 <= skid_vld_q ? skid_val_q : val9;
			sat_s9 <= skid_vld_q ? skid_sat_q : sat9;
		end else if (incoming) begin
			skid_val_q <= val9;
			skid_sat_q <= sat9;
		end
	end

	assign m_tvalid = vld_s9;
	assign m_tdata  = OUT_TW'(val_s9);
	assign m_tuser  = sat_s9;

	// ---------------- assertions ----------------
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(val_s9 == HI[VALUE_WIDTH-1:0]) || (val_s9 == LO[VALUE_WIDTH-1:0]))
		else $error("saturated beat not at a range limit");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> m_tvalid)
		else $error("skid holds a beat while the output is empty");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ue_s1 <= ONE_U)
		else $error("fraction above one");

	a_eased_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && fam_s6 != FAM_BACK |-> !e_s6[EW-1] && e_s6 <= ONE_E)
		else $error("eased fraction outside [0, one] for a non-back curve");

	a_back_coef: assert property (@(posedge clk) disable iff (!arst_n)
		$past(bo_q) == bo_q && $past(bo_q, 2) == bo_q && $past(bo_q, 3) == bo_q
			|-> s2_q >= s_q)
		else $error("in-out back overshoot below plain overshoot");

endmodule

`default_nettype wire
